// ===== hdl/ipms_pkg.sv =====
// Shared types and constants of the incremental PID motor speed controller.
`default_nettype none

package ipms_pkg;

    // Field widths fixed by the interface.
    localparam int SPEED_W = 16;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int GAIN_W  = 16;
    localparam int ACC_W   = 32;
    localparam int DRIVE_W = 17;
    // Products of a 17-bit signed gain with error terms of up to 19 bits.
    localparam int PROD_W  = 36;
    // Accumulator plus three products, exact before the clamp.
    localparam int SUM_W   = 38;

    localparam logic [GAIN_W-1:0] GAIN_ERROR_RST     = 16'd150;
    localparam logic [GAIN_W-1:0] GAIN_CHANGE_RST    = 16'd100;
    localparam logic [GAIN_W-1:0] GAIN_CURVATURE_RST = 16'd100;
    localparam logic [GAIN_W-1:0] DRIVE_LIMIT_RST    = 16'd1000;

    typedef enum logic [1:0] {
        CFG_GAIN_ERROR           = 2'd0,
        CFG_GAIN_ERROR_CHANGE    = 2'd1,
        CFG_GAIN_ERROR_CURVATURE = 2'd2,
        CFG_DRIVE_LIMIT          = 2'd3
    } cfg_index_t;

    // Per-motor controller state as kept in the state memory.
    typedef struct packed {
        logic signed [ERR_W-1:0] last_error;
        logic signed [ERR_W-1:0] prior_error;
        logic signed [ACC_W-1:0] drive_acc;
    } ipms_state_t;

endpackage

`default_nettype wire

// ===== hdl/ipms_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ipms_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/incremental_pid_motor_speed.sv =====
// Incremental PID speed controller for NUM_MOTORS motors. Each input beat names a
// motor and carries measured and commanded speed (signed, SPEED_FRAC_BITS fraction
// bits); the output beat carries that motor's new integer PWM drive and a flag set
// when the drive accumulator was clamped to +/- drive_limit. The block takes one
// beat every cycle while the output is not stalled. The state memory has separate
// read and write ports: it is read at the accepting edge and written back from
// stage 2, with forwarding between beats of the same motor, so it never limits
// the rate. Back-pressure on the output holds the whole pipeline. The gains and
// the limit may only be written while no beat is in flight.
`default_nettype none

module incremental_pid_motor_speed
    import ipms_pkg::*;
#(
    parameter int NUM_MOTORS      = 2,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits 15:0 measured_speed, bits 31:16 commanded_speed.
    input  logic [31:0] s_axis_tdata,
    // Bit 0 motor.
    input  logic [0:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits 16:0 drive, bits 23:17 zero.
    output logic [23:0] m_axis_tdata,
    // Bit 0 motor_out, bit 1 limited.
    output logic [1:0]  m_axis_tuser,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int ENT_W = $bits(ipms_state_t);

    // Configuration registers.
    logic [GAIN_W-1:0] gain_error_reg;
    logic [GAIN_W-1:0] gain_change_reg;
    logic [GAIN_W-1:0] gain_curv_reg;
    logic [GAIN_W-1:0] drive_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_error_reg  <= GAIN_ERROR_RST;
            gain_change_reg <= GAIN_CHANGE_RST;
            gain_curv_reg   <= GAIN_CURVATURE_RST;
            drive_limit_reg <= DRIVE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_ERROR:           gain_error_reg  <= cfg_data;
                CFG_GAIN_ERROR_CHANGE:    gain_change_reg <= cfg_data;
                CFG_GAIN_ERROR_CURVATURE: gain_curv_reg   <= cfg_data;
                CFG_DRIVE_LIMIT:          drive_limit_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Pipeline registers.
    logic                     out_valid_reg;
    logic                     adv;
    logic                     in_fire;

    logic                     s1_valid_reg;
    logic                     s1_ok_reg;
    logic                     s1_motor_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;

    logic                     s2_valid_reg;
    logic                     s2_ok_reg;
    logic                     s2_motor_reg;
    logic signed [ERR_W-1:0]  s2_err_reg;
    logic signed [ERR_W-1:0]  s2_e1_reg;
    logic signed [ACC_W-1:0]  s2_acc_reg;
    logic signed [PROD_W-1:0] s2_p0_reg;
    logic signed [PROD_W-1:0] s2_p1_reg;
    logic signed [PROD_W-1:0] s2_p2_reg;

    // Copy of the entry written back at the last advancing edge.
    logic                     w_valid_reg;
    logic                     w_motor_reg;
    ipms_state_t              w_state_reg;

    logic [NUM_MOTORS-1:0]    slot_valid_reg;

    logic                     out_motor_reg;
    logic                     out_limited_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;

    // The whole pipeline moves when the output register is free or being emptied.
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;

    // Input stage.
    logic signed [SPEED_W-1:0] in_measured;
    logic signed [SPEED_W-1:0] in_target;
    logic                      in_motor;
    logic                      in_ok;
    logic signed [ERR_W-1:0]   s1_err_next;

    assign in_measured = signed'(s_axis_tdata[15:0]);
    assign in_target   = signed'(s_axis_tdata[31:16]);
    assign in_motor    = s_axis_tuser[0];
    assign in_ok       = {31'd0, in_motor} < 32'(NUM_MOTORS);
    assign s1_err_next = ERR_W'(in_target) - ERR_W'(in_measured);

    // State memory.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ENT_W-1:0]  ram_rdata;
    ipms_state_t       s2_state_next;

    ipms_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_MOTORS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s2_state_next),
        .re    (adv),
        .raddr (AW'(in_motor)),
        .rdata (ram_rdata)
    );

    // Stage 1: pick the freshest state, form the error differences and products.
    ipms_state_t               rd_state;
    logic                      s2_hit;
    logic                      w_hit1;
    logic signed [ERR_W-1:0]   e1;
    logic signed [ERR_W-1:0]   e2;
    logic signed [ACC_W-1:0]   s1_acc;
    logic signed [ERR_W:0]     d1;
    logic signed [ERR_W+1:0]   d2;
    logic signed [GAIN_W:0]    g0;
    logic signed [GAIN_W:0]    g1;
    logic signed [GAIN_W:0]    g2;
    logic signed [PROD_W-1:0]  p0_next;
    logic signed [PROD_W-1:0]  p1_next;
    logic signed [PROD_W-1:0]  p2_next;

    // An entry never written reads as zero.
    assign rd_state = slot_valid_reg[AW'(s1_motor_reg)] ? ipms_state_t'(ram_rdata) : '0;
    assign s2_hit   = s2_valid_reg && s2_ok_reg && (s2_motor_reg == s1_motor_reg);
    assign w_hit1   = w_valid_reg && (w_motor_reg == s1_motor_reg);

    always_comb
    begin
        if (s2_hit)
        begin
            e1 = s2_err_reg;
            e2 = s2_e1_reg;
        end
        else if (w_hit1)
        begin
            e1 = w_state_reg.last_error;
            e2 = w_state_reg.prior_error;
        end
        else
        begin
            e1 = rd_state.last_error;
            e2 = rd_state.prior_error;
        end
    end

    // A newer accumulator from the beat now in stage 2 is taken there instead.
    assign s1_acc = w_hit1 ? w_state_reg.drive_acc : rd_state.drive_acc;

    assign d1 = (ERR_W+1)'(s1_err_reg) - (ERR_W+1)'(e1);
    assign d2 = (ERR_W+2)'(s1_err_reg) - ((ERR_W+2)'(e1) <<< 1) + (ERR_W+2)'(e2);

    assign g0 = signed'({1'b0, gain_error_reg});
    assign g1 = signed'({1'b0, gain_change_reg});
    assign g2 = signed'({1'b0, gain_curv_reg});

    assign p0_next = PROD_W'(g0) * PROD_W'(s1_err_reg);
    assign p1_next = PROD_W'(g1) * PROD_W'(d1);
    assign p2_next = PROD_W'(g2) * PROD_W'(d2);

    // Stage 2: accumulate, clamp, write back and scale to PWM counts.
    logic                      w_hit2;
    logic signed [ACC_W-1:0]   acc_old;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   lim;
    logic signed [SUM_W-1:0]   acc_sat;
    logic                      clamp_hi;
    logic                      clamp_lo;
    logic signed [ACC_W-1:0]   acc_new;
    logic [ACC_W-1:0]          acc_mag;
    logic [ACC_W-1:0]          acc_quot;
    logic signed [DRIVE_W-1:0] drive_next;

    assign w_hit2  = w_valid_reg && (w_motor_reg == s2_motor_reg);
    assign acc_old = w_hit2 ? w_state_reg.drive_acc : s2_acc_reg;
    assign total   = SUM_W'(acc_old) + SUM_W'(s2_p0_reg) + SUM_W'(s2_p1_reg)
                   + SUM_W'(s2_p2_reg);
    assign lim     = signed'(SUM_W'(drive_limit_reg) << SPEED_FRAC_BITS);

    assign clamp_hi = total > lim;
    assign clamp_lo = total < -lim;
    assign acc_sat  = clamp_hi ? lim : (clamp_lo ? -lim : total);
    assign acc_new  = acc_sat[ACC_W-1:0];

    // Division by the fraction scale truncates toward zero.
    assign acc_mag    = acc_new[ACC_W-1] ? unsigned'(-acc_new) : unsigned'(acc_new);
    assign acc_quot   = acc_mag >> SPEED_FRAC_BITS;
    assign drive_next = acc_new[ACC_W-1] ? -signed'(acc_quot[DRIVE_W-1:0])
                                         : signed'(acc_quot[DRIVE_W-1:0]);

    always_comb
    begin
        s2_state_next.last_error  = s2_err_reg;
        s2_state_next.prior_error = s2_e1_reg;
        s2_state_next.drive_acc   = acc_new;
    end

    assign ram_we    = adv && s2_valid_reg && s2_ok_reg;
    assign ram_waddr = AW'(s2_motor_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            w_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_fire;
            s2_valid_reg  <= s1_valid_reg;
            w_valid_reg   <= s2_valid_reg && s2_ok_reg;
            out_valid_reg <= s2_valid_reg;
            if (ram_we)
            begin
                slot_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg    <= in_ok;
            s1_motor_reg <= in_motor;
            s1_err_reg   <= s1_err_next;

            s2_ok_reg    <= s1_ok_reg;
            s2_motor_reg <= s1_motor_reg;
            s2_err_reg   <= s1_err_reg;
            s2_e1_reg    <= e1;
            s2_acc_reg   <= s1_acc;
            s2_p0_reg    <= p0_next;
            s2_p1_reg    <= p1_next;
            s2_p2_reg    <= p2_next;

            w_motor_reg  <= s2_motor_reg;
            w_state_reg  <= s2_state_next;

            out_motor_reg <= s2_motor_reg;
            if (s2_ok_reg)
            begin
                out_drive_reg   <= drive_next;
                out_limited_reg <= clamp_hi || clamp_lo;
            end
            else
            begin
                out_drive_reg   <= '0;
                out_limited_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_drive_reg};
    assign m_axis_tuser  = {out_limited_reg, out_motor_reg};

endmodule

`default_nettype wire

// ===== tb/incremental_pid_motor_speed_test.sv =====
// Self-checking testbench for the incremental PID motor speed controller.
module incremental_pid_motor_speed_test
    import ipms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOTORS       = 2;
    localparam int FRAC_BITS    = 8;
    localparam int PIPE_LATENCY = 3;
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 92;

    typedef struct packed {
        logic                      motor;
        logic signed [DRIVE_W-1:0] drive;
        logic                      limited;
    } drive_result_t;

    typedef enum bit {
        ROW_BEAT,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        cfg_index_t                reg_sel;
        logic [GAIN_W-1:0]         value;
        logic                      motor;
        logic signed [SPEED_W-1:0] measured;
        logic signed [SPEED_W-1:0] target;
        bit                        typed;
        drive_result_t             result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // Bits 15:0 measured_speed, bits 31:16 commanded_speed.
    logic [31:0] s_axis_tdata;
    // Bit 0 motor.
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // Bits 16:0 drive, bits 23:17 zero.
    logic [23:0] m_axis_tdata;
    // Bit 0 motor_out, bit 1 limited.
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Software copy of the controller: gains, limit and per-motor history.
    logic [GAIN_W-1:0]         k_err;
    logic [GAIN_W-1:0]         k_change;
    logic [GAIN_W-1:0]         k_curv;
    logic [GAIN_W-1:0]         limit_counts;
    logic signed [ERR_W-1:0]   err_last [MOTORS];
    logic signed [ERR_W-1:0]   err_prior [MOTORS];
    logic signed [ACC_W-1:0]   acc_counts [MOTORS];

    drive_result_t pending_drives[$];
    drive_result_t want;
    stim_row_t     directed[$];
    int            mismatches = 0;
    int            stuck = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;
    int            set_point [MOTORS];

    incremental_pid_motor_speed #(
        .NUM_MOTORS      (MOTORS),
        .SPEED_FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advances one motor's history and returns the drive it should report.
    function automatic drive_result_t next_drive(logic motor,
                                                 logic signed [SPEED_W-1:0] measured,
                                                 logic signed [SPEED_W-1:0] target);
        longint        e;
        longint        e1;
        longint        e2;
        longint        sum;
        longint        acc;
        longint        lim;
        longint        whole;
        drive_result_t r;
        e   = longint'(target) - longint'(measured);
        e1  = longint'(err_last[motor]);
        e2  = longint'(err_prior[motor]);
        sum = longint'(k_err) * e
            + longint'(k_change) * (e - e1)
            + longint'(k_curv) * (e - 2 * e1 + e2);
        acc = longint'(acc_counts[motor]) + sum;
        err_prior[motor] = err_last[motor];
        err_last[motor]  = e[ERR_W-1:0];
        lim = longint'(limit_counts) << FRAC_BITS;
        r.limited = 1'b0;
        if (acc > lim)
        begin
            acc = lim;
            r.limited = 1'b1;
        end
        else if (acc < -lim)
        begin
            acc = -lim;
            r.limited = 1'b1;
        end
        acc_counts[motor] = acc[ACC_W-1:0];
        // Signed division truncates toward zero, as the drive output does.
        whole = acc / (longint'(1) << FRAC_BITS);
        r.motor = motor;
        r.drive = whole[DRIVE_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t beat_row(int motor, int measured, int target);
        stim_row_t r;
        r.kind     = ROW_BEAT;
        r.reg_sel  = CFG_GAIN_ERROR;
        r.value    = '0;
        r.motor    = motor[0];
        r.measured = measured[SPEED_W-1:0];
        r.target   = target[SPEED_W-1:0];
        r.typed    = 1'b0;
        r.result   = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(int motor, int measured, int target,
                                            int drive, int limited);
        stim_row_t r;
        r = beat_row(motor, measured, target);
        r.typed          = 1'b1;
        r.result.motor   = motor[0];
        r.result.drive   = drive[DRIVE_W-1:0];
        r.result.limited = limited[0];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_index_t sel, int value);
        stim_row_t r;
        r = beat_row(0, 0, 0);
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.value   = value[GAIN_W-1:0];
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return 16'($urandom_range(0, 400));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return 16'($urandom_range(1, 2000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic check_field(string what, longint want_v, longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the write.
    task automatic write_reg(cfg_index_t sel, logic [GAIN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        case (sel)
            CFG_GAIN_ERROR:           k_err        = value;
            CFG_GAIN_ERROR_CHANGE:    k_change     = value;
            CFG_GAIN_ERROR_CURVATURE: k_curv       = value;
            CFG_DRIVE_LIMIT:          limit_counts = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(logic motor, logic signed [SPEED_W-1:0] measured,
                             logic signed [SPEED_W-1:0] target, bit typed,
                             drive_result_t typed_result);
        drive_result_t predicted;
        cfg_we <= 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {target, measured};
        s_axis_tuser  <= motor;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = next_drive(motor, measured, target);
        pending_drives.push_back(typed ? typed_result : predicted);
        @(negedge clk);
    endtask

    // Lets every outstanding beat come out before the registers change.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 1) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (quiet)
            m_axis_tready <= 1'b1;
        else if (stall_left != 0)
            stall_left--;
        else if ($urandom_range(0, 9) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_drives.size() == 0)
            begin
                $display("%0t ns: result beat with nothing expected, drive %0d", $time,
                         $signed(m_axis_tdata[DRIVE_W-1:0]));
                mismatches++;
            end
            else
            begin
                want = pending_drives.pop_front();
                check_field("motor_out", want.motor, m_axis_tuser[0]);
                check_field("drive", want.drive, $signed(m_axis_tdata[DRIVE_W-1:0]));
                check_field("limited", want.limited, m_axis_tuser[1]);
                check_field("tdata padding", 0, m_axis_tdata[23:DRIVE_W]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
            begin
                stuck++;
                if (stuck >= STUCK_LIMIT)
                begin
                    $display("%0t ns: no beat moved for %0d cycles", $time, stuck);
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        bit busy;
        int m;
        int meas;
        int tgt;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        k_err         = GAIN_ERROR_RST;
        k_change      = GAIN_CHANGE_RST;
        k_curv        = GAIN_CURVATURE_RST;
        limit_counts  = DRIVE_LIMIT_RST;
        for (int i = 0; i < MOTORS; i++)
        begin
            err_last[i]   = '0;
            err_prior[i]  = '0;
            acc_counts[i] = '0;
            set_point[i]  = 0;
        end

        // Reset gains and limit first, then the largest errors of either sign.
        directed.push_back(typed_row(0, 0, 0, 0, 0));
        directed.push_back(typed_row(0, -32768, 32767, 1000, 1));
        directed.push_back(typed_row(1, 32767, -32768, -1000, 1));
        // A zero limit pins the drive at zero and flags any nonzero step.
        directed.push_back(cfg_row(CFG_DRIVE_LIMIT, 0));
        directed.push_back(typed_row(0, 0, 0, 0, 1));
        directed.push_back(typed_row(1, 0, 0, 0, 1));
        directed.push_back(typed_row(0, 0, 0, 0, 1));
        directed.push_back(typed_row(0, 0, 0, 0, 0));
        // Landing exactly on the limit does not count as clamping.
        directed.push_back(cfg_row(CFG_GAIN_ERROR, 256));
        directed.push_back(cfg_row(CFG_GAIN_ERROR_CHANGE, 0));
        directed.push_back(cfg_row(CFG_GAIN_ERROR_CURVATURE, 0));
        directed.push_back(cfg_row(CFG_DRIVE_LIMIT, 1));
        directed.push_back(typed_row(0, 0, 1, 1, 0));
        directed.push_back(typed_row(0, 0, 1, 1, 1));
        directed.push_back(typed_row(1, 1, 0, -1, 0));
        // A negative fraction of a count rounds toward zero.
        directed.push_back(cfg_row(CFG_GAIN_ERROR, 100));
        directed.push_back(cfg_row(CFG_DRIVE_LIMIT, 1000));
        directed.push_back(typed_row(1, 0, 1, 0, 0));
        directed.push_back(cfg_row(CFG_GAIN_ERROR, 65535));
        directed.push_back(cfg_row(CFG_GAIN_ERROR_CHANGE, 65535));
        directed.push_back(cfg_row(CFG_GAIN_ERROR_CURVATURE, 65535));
        directed.push_back(cfg_row(CFG_DRIVE_LIMIT, 65535));
        directed.push_back(typed_row(0, -32768, 32767, 65535, 1));
        directed.push_back(typed_row(0, 32767, -32768, -65535, 1));
        directed.push_back(beat_row(1, 1234, -4321));
        directed.push_back(cfg_row(CFG_GAIN_ERROR, 0));
        directed.push_back(cfg_row(CFG_GAIN_ERROR_CHANGE, 0));
        directed.push_back(cfg_row(CFG_GAIN_ERROR_CURVATURE, 0));
        directed.push_back(beat_row(1, 32767, 4660));
        directed.push_back(beat_row(0, -1, 5));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        busy = 1'b0;
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                if (busy)
                begin
                    settle();
                    busy = 1'b0;
                end
                write_reg(directed[i].reg_sel, directed[i].value);
            end
            else
            begin
                send_beat(directed[i].motor, directed[i].measured, directed[i].target,
                          directed[i].typed, directed[i].result);
                busy = 1'b1;
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            write_reg(CFG_GAIN_ERROR, pick_gain());
            write_reg(CFG_GAIN_ERROR_CHANGE, pick_gain());
            write_reg(CFG_GAIN_ERROR_CURVATURE, pick_gain());
            write_reg(CFG_DRIVE_LIMIT, pick_limit());
            quiet = (phase == PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                m = $urandom_range(0, MOTORS - 1);
                case ($urandom_range(0, 9))
                    0:
                    begin
                        set_point[m] = int'($urandom_range(0, 65535)) - 32768;
                        tgt  = set_point[m];
                        meas = tgt + int'($urandom_range(0, 600)) - 300;
                    end
                    1:
                    begin
                        tgt  = int'($urandom_range(0, 65535));
                        meas = int'($urandom_range(0, 65535));
                    end
                    default:
                    begin
                        // Speed tracking close to a held set point.
                        tgt  = set_point[m];
                        meas = tgt + int'($urandom_range(0, 600)) - 300;
                    end
                endcase
                send_beat(m[0], meas[SPEED_W-1:0], tgt[SPEED_W-1:0], 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
